### rtl/gsa_pkg.sv
// Shared types and constants of the global sequence aligner.
package gsa_pkg;

    localparam int MAX_LEN_DEF     = 32;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int SYM_W   = 8;   // symbol field width on the ports
    localparam int SCORE_W = 15;  // signed score width
    localparam int CNT_W   = 7;   // count fields (0..64)
    localparam int CFG_W   = 8;   // configuration register width
    localparam int OP_W    = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MATCH    = 2'd0;
    localparam logic [1:0] CFG_MISMATCH = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;

    // Traceback move codes.
    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_DEL  = 2'd2;
    localparam logic [1:0] DIR_INS  = 2'd3;

    // Data handed from one cell to its right neighbor.
    typedef struct packed {
        logic                      valid;
        logic [SYM_W-1:0]          sym_a;
        logic signed [SCORE_W-1:0] h_left;
        logic signed [SCORE_W-1:0] h_diag;
    } t_link;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_TRACE = 5'b00100,
        ST_RD    = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

endpackage

### rtl/gsa_cell.sv
// One column cell of the systolic score array, with its column of directions.
module gsa_cell #(
    parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF,
    parameter int COL     = 1,
    localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [gsa_pkg::SYM_W-1:0]         i_sym_b,
    input  logic signed [gsa_pkg::CFG_W-1:0]  i_match,
    input  logic signed [gsa_pkg::CFG_W-1:0]  i_mismatch,
    input  logic signed [gsa_pkg::CFG_W-1:0]  i_gap,
    input  gsa_pkg::t_link                    i_link,
    output gsa_pkg::t_link                    o_link,
    input  logic [IW-1:0]                     i_rd_row,
    output logic [1:0]                        o_dir,
    output logic signed [gsa_pkg::SCORE_W-1:0] o_h
);
    localparam logic signed [gsa_pkg::SCORE_W-1:0] COL_S = gsa_pkg::SCORE_W'(COL);

    logic signed [gsa_pkg::SCORE_W-1:0] r_h;
    logic [IW-1:0]                      r_row;
    logic [1:0]                         r_dir [MAX_LEN];
    gsa_pkg::t_link                     r_out;

    logic signed [gsa_pkg::SCORE_W-1:0] w_gap, w_sub, w_d, w_del, w_ins, w_best, w_init;
    logic [1:0]                         w_dir;

    always_comb begin
        w_gap  = gsa_pkg::SCORE_W'(i_gap);
        w_sub  = (i_link.sym_a == i_sym_b) ? gsa_pkg::SCORE_W'(i_match)
                                           : gsa_pkg::SCORE_W'(i_mismatch);
        w_d    = i_link.h_diag + w_sub;
        w_del  = r_h + w_gap;
        w_ins  = i_link.h_left + w_gap;
        w_best = w_d;
        w_dir  = gsa_pkg::DIR_DIAG;
        if (w_del > w_best) begin
            w_best = w_del;
            w_dir  = gsa_pkg::DIR_DEL;
        end
        if (w_ins > w_best) begin
            w_best = w_ins;
            w_dir  = gsa_pkg::DIR_INS;
        end
        w_init = COL_S * w_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
            r_row       <= '0;
        end else if (i_start) begin
            r_out.valid <= 1'b0;
            r_row       <= '0;
            r_h         <= w_init;
        end else begin
            r_out.valid <= i_link.valid;
            if (i_link.valid) begin
                r_row        <= r_row + 1'b1;
                r_h          <= w_best;
                r_dir[r_row] <= w_dir;
                r_out.sym_a  <= i_link.sym_a;
                r_out.h_left <= w_best;
                r_out.h_diag <= r_h;
            end
        end
    end

    assign o_link = r_out;
    assign o_dir  = r_dir[i_rd_row];
    assign o_h    = r_h;
endmodule

### rtl/global_sequence_aligner_top.sv
// Top level of the global sequence aligner: stores, control and systolic cell row.
//
// Input stream (s_axis): each transfer is one item. op OP_APPEND_A/OP_APPEND_B
// appends a symbol to sequence A or B, one per cycle; symbols past MAX_LEN are
// dropped and the overflow flag is set. op OP_RUN starts an alignment; op 3 is
// ignored. Output stream (m_axis): one transfer per aligned column, first to
// last; tlast marks the final column, which also carries score and counts.
// Two empty sequences give one transfer with column_valid low and tlast high.
// Configuration: three signed 8-bit scores written by index; the user must write
// them only while idle, as the block itself does not enforce it. A run sweeps
// row after row of A through the MAX_LEN column cells, then traces back step
// by step until it sees the origin, then emits each column by a path memory
// read (ST_RD) and an output register load (ST_OUT). While a run is in
// progress s_axis_tready is low.
// Reset clears lengths, overflow flag, scores to 1/-1/-2 and all control.
// A stall on m_axis holds the output register and pauses emission; once the
// last column is loaded the block accepts new items while it waits.
module global_sequence_aligner_top #(
    parameter int MAX_LEN     = gsa_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = gsa_pkg::SYMBOL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] op, [9:2] symbol, [15:10] zero
    input  logic [gsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] sym_a, [15:8] sym_b, [16] gap_in_a, [17] gap_in_b, [18] is_match,
    // [33:19] total_score, [40:34] match_count, [47:41] gap_count,
    // [54:48] column_count, [55] overflow
    output logic [gsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] column_valid
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_wr_en,
    input  logic [1:0]                         i_cfg_index,
    input  logic [gsa_pkg::CFG_W-1:0]          i_cfg_data
);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(2 * MAX_LEN);
    localparam int CW = gsa_pkg::CNT_W;
    localparam int SW = gsa_pkg::SCORE_W;

    gsa_pkg::t_state r_state;

    logic signed [gsa_pkg::CFG_W-1:0] r_match, r_mismatch, r_gap;
    logic [SYMBOL_BITS-1:0] r_seq_a [MAX_LEN];
    logic [SYMBOL_BITS-1:0] r_seq_b [MAX_LEN];
    logic [LW-1:0]          r_len_a, r_len_b;
    logic                   r_ovf;

    logic [CW-1:0]          r_cnt;
    logic signed [SW-1:0]   r_h0;
    logic [LW-1:0]          r_ti, r_tj, r_ei, r_ej;
    logic [CW-1:0]          r_cols, r_mc, r_gc, r_k;
    logic [1:0]             r_path [2*MAX_LEN];
    logic [1:0]             r_path_q;

    logic                          r_ovalid;
    logic [gsa_pkg::OUT_TDATA_W-1:0] r_odata;
    logic                          r_ouser, r_olast;

    // Input item decode.
    logic [gsa_pkg::OP_W-1:0] w_op;
    logic [SYMBOL_BITS-1:0]   w_sym;
    logic                     w_in_acc;
    assign w_op     = s_axis_tdata[1:0];
    assign w_sym    = s_axis_tdata[2 +: SYMBOL_BITS];
    assign s_axis_tready = (r_state == gsa_pkg::ST_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Shared read addresses of the two symbol stores.
    logic [IW-1:0] w_a_addr, w_b_addr;
    logic [SYMBOL_BITS-1:0] w_a_sym, w_b_sym;
    always_comb begin
        w_a_addr = IW'(r_ei);
        w_b_addr = IW'(r_ej);
        if (r_state == gsa_pkg::ST_FILL) begin
            w_a_addr = IW'(r_cnt);
        end else if (r_state == gsa_pkg::ST_TRACE) begin
            w_a_addr = IW'(r_ti - 1'b1);
            w_b_addr = IW'(r_tj - 1'b1);
        end
    end
    assign w_a_sym = r_seq_a[w_a_addr];
    assign w_b_sym = r_seq_b[w_b_addr];

    // Boundary column feeding rows of A into the cell row.
    logic                 w_start;
    logic                 w_feed;
    logic signed [SW-1:0] w_gap15;
    gsa_pkg::t_link       w_link [MAX_LEN+1];
    logic [1:0]           w_cell_dir [MAX_LEN];
    logic signed [SW-1:0] w_cell_h [MAX_LEN];
    logic [IW-1:0]        w_rd_row;

    assign w_start  = w_in_acc && (w_op == gsa_pkg::OP_RUN);
    assign w_gap15  = SW'(r_gap);
    assign w_feed   = (r_state == gsa_pkg::ST_FILL) && (r_cnt < CW'(r_len_a));
    assign w_rd_row = IW'(r_ti - 1'b1);

    always_comb begin
        w_link[0].valid  = w_feed;
        w_link[0].sym_a  = gsa_pkg::SYM_W'(w_a_sym);
        w_link[0].h_diag = r_h0;
        w_link[0].h_left = r_h0 + w_gap15;
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        gsa_cell #(
            .MAX_LEN (MAX_LEN),
            .COL     (g + 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_start),
            .i_sym_b    (gsa_pkg::SYM_W'(r_seq_b[g])),
            .i_match    (r_match),
            .i_mismatch (r_mismatch),
            .i_gap      (r_gap),
            .i_link     (w_link[g]),
            .o_link     (w_link[g+1]),
            .i_rd_row   (w_rd_row),
            .o_dir      (w_cell_dir[g]),
            .o_h        (w_cell_h[g])
        );
    end

    // Traceback move selection; row zero and column zero are fixed borders.
    logic [1:0] w_dir, w_move;
    logic       w_tb_done;
    assign w_tb_done = (r_ti == '0) && (r_tj == '0);
    always_comb begin
        if (r_ti == '0) begin
            w_dir = gsa_pkg::DIR_INS;
        end else if (r_tj == '0) begin
            w_dir = gsa_pkg::DIR_DEL;
        end else begin
            w_dir = w_cell_dir[IW'(r_tj - 1'b1)];
        end
        if (r_ti != '0 && r_tj != '0 && w_dir == gsa_pkg::DIR_DIAG) begin
            w_move = gsa_pkg::DIR_DIAG;
        end else if (r_ti != '0 && (w_dir == gsa_pkg::DIR_DEL || r_tj == '0)) begin
            w_move = gsa_pkg::DIR_DEL;
        end else begin
            w_move = gsa_pkg::DIR_INS;
        end
    end

    // Final score: corner cell, or the border when B is empty.
    logic signed [SW-1:0] w_total;
    assign w_total = (r_len_b == '0) ? r_h0 : w_cell_h[IW'(r_len_b - 1'b1)];

    // Column being emitted.
    logic        w_fin, w_empty, w_oready;
    logic [7:0]  w_sa, w_sb;
    logic        w_ga, w_gb, w_im;
    logic [gsa_pkg::OUT_TDATA_W-1:0] w_odata;
    assign w_empty  = (r_cols == '0);
    assign w_fin    = w_empty || (r_k + 1'b1 == r_cols);
    assign w_oready = !r_ovalid || m_axis_tready;
    always_comb begin
        w_sa = '0;
        w_sb = '0;
        w_ga = 1'b0;
        w_gb = 1'b0;
        if (!w_empty) begin
            case (r_path_q)
                gsa_pkg::DIR_DIAG: begin
                    w_sa = 8'(w_a_sym);
                    w_sb = 8'(w_b_sym);
                end
                gsa_pkg::DIR_DEL: begin
                    w_sa = 8'(w_a_sym);
                    w_gb = 1'b1;
                end
                default: begin
                    w_sb = 8'(w_b_sym);
                    w_ga = 1'b1;
                end
            endcase
        end
        w_im    = !w_empty && !w_ga && !w_gb && (w_sa == w_sb);
        w_odata = '0;
        w_odata[7:0]   = w_sa;
        w_odata[15:8]  = w_sb;
        w_odata[16]    = w_ga;
        w_odata[17]    = w_gb;
        w_odata[18]    = w_im;
        if (w_fin && !w_empty) begin
            w_odata[33:19] = w_total;
            w_odata[40:34] = r_mc;
            w_odata[47:41] = r_gc;
            w_odata[54:48] = r_cols;
        end
        w_odata[55] = r_ovf;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 8'sd1;
            r_mismatch <= -8'sd1;
            r_gap      <= -8'sd2;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gsa_pkg::CFG_MATCH:    r_match    <= i_cfg_data;
                gsa_pkg::CFG_MISMATCH: r_mismatch <= i_cfg_data;
                gsa_pkg::CFG_GAP:      r_gap      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Symbol stores and path memory.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_op == gsa_pkg::OP_APPEND_A && r_len_a < LW'(MAX_LEN)) begin
            r_seq_a[IW'(r_len_a)] <= w_sym;
        end
        if (w_in_acc && w_op == gsa_pkg::OP_APPEND_B && r_len_b < LW'(MAX_LEN)) begin
            r_seq_b[IW'(r_len_b)] <= w_sym;
        end
        if (r_state == gsa_pkg::ST_TRACE && !w_tb_done) begin
            r_path[PW'(r_cols)] <= w_move;
        end
        r_path_q <= r_path[PW'(r_cols - 1'b1 - r_k)];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gsa_pkg::ST_IDLE;
            r_len_a  <= '0;
            r_len_b  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // A new column loads the output register; otherwise a transfer empties it.
            if (r_state == gsa_pkg::ST_OUT && w_oready) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                gsa_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        case (w_op)
                            gsa_pkg::OP_APPEND_A: begin
                                if (r_len_a < LW'(MAX_LEN)) r_len_a <= r_len_a + 1'b1;
                                else r_ovf <= 1'b1;
                            end
                            gsa_pkg::OP_APPEND_B: begin
                                if (r_len_b < LW'(MAX_LEN)) r_len_b <= r_len_b + 1'b1;
                                else r_ovf <= 1'b1;
                            end
                            gsa_pkg::OP_RUN: r_state <= gsa_pkg::ST_FILL;
                            default: ;
                        endcase
                    end
                end
                gsa_pkg::ST_FILL: begin
                    if (r_cnt == CW'(r_len_a) + CW'(MAX_LEN)) begin
                        r_state <= gsa_pkg::ST_TRACE;
                    end
                end
                gsa_pkg::ST_TRACE: begin
                    if (w_tb_done) r_state <= gsa_pkg::ST_RD;
                end
                gsa_pkg::ST_RD: r_state <= gsa_pkg::ST_OUT;
                gsa_pkg::ST_OUT: begin
                    if (w_oready) begin
                        if (w_fin) begin
                            r_state <= gsa_pkg::ST_IDLE;
                            r_len_a <= '0;
                            r_len_b <= '0;
                            r_ovf   <= 1'b0;
                        end else begin
                            r_state <= gsa_pkg::ST_RD;
                        end
                    end
                end
                default: r_state <= gsa_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath counters of fill, traceback and emission.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cnt <= '0;
            r_h0  <= '0;
        end else if (r_state == gsa_pkg::ST_FILL) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_feed) r_h0 <= r_h0 + w_gap15;
        end
        if (r_state == gsa_pkg::ST_FILL) begin
            r_ti   <= r_len_a;
            r_tj   <= r_len_b;
            r_cols <= '0;
            r_mc   <= '0;
            r_gc   <= '0;
        end else if (r_state == gsa_pkg::ST_TRACE && !w_tb_done) begin
            r_cols <= r_cols + 1'b1;
            case (w_move)
                gsa_pkg::DIR_DIAG: begin
                    r_ti <= r_ti - 1'b1;
                    r_tj <= r_tj - 1'b1;
                    if (w_a_sym == w_b_sym) r_mc <= r_mc + 1'b1;
                end
                gsa_pkg::DIR_DEL: begin
                    r_ti <= r_ti - 1'b1;
                    r_gc <= r_gc + 1'b1;
                end
                default: begin
                    r_tj <= r_tj - 1'b1;
                    r_gc <= r_gc + 1'b1;
                end
            endcase
        end
        if (r_state == gsa_pkg::ST_TRACE) begin
            r_k  <= '0;
            r_ei <= '0;
            r_ej <= '0;
        end else if (r_state == gsa_pkg::ST_OUT && w_oready) begin
            r_k <= r_k + 1'b1;
            case (r_path_q)
                gsa_pkg::DIR_DIAG: begin
                    r_ei <= r_ei + 1'b1;
                    r_ej <= r_ej + 1'b1;
                end
                gsa_pkg::DIR_DEL: r_ei <= r_ei + 1'b1;
                default:          r_ej <= r_ej + 1'b1;
            endcase
        end
        if (r_state == gsa_pkg::ST_OUT && w_oready) begin
            r_odata <= w_odata;
            r_ouser <= !w_empty;
            r_olast <= w_fin;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;
endmodule
